/* hdl/wps_pkg.sv */
// Shared types and constants for the weighted path selector.
`timescale 1ns / 1ps
package wps_pkg;

	localparam logic [16:0] FACTOR_ONE      = 17'd65536;
	localparam logic [16:0] FACTOR_FLOOR    = 17'd6554;
	localparam logic [15:0] PEN_LIMIT       = 16'd58982;  // 65536 - 6554
	localparam logic [31:0] NO_PATH_MIN_RTT = 32'd10000;
	localparam logic [25:0] US_PER_MS       = 26'd1000;
	localparam logic [28:0] PENALTY_SPAN    = 29'd5;
	localparam int          FDIV_STEPS      = 16;
	localparam int          MOD_STEPS       = 32;

	typedef enum logic [1:0] {
		CFG_PATHS_IN_USE  = 2'd0,
		CFG_LAT_THRESHOLD = 2'd1,
		CFG_TOTAL_CHUNKS  = 2'd2,
		CFG_UNUSED        = 2'd3
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MIN,
		ST_FAC,
		ST_FDIV,
		ST_MUL,
		ST_TGT_LO,
		ST_TGT_HI,
		ST_TDIV,
		ST_WALK,
		ST_MDIV,
		ST_MWALK
	} state_t;

endpackage

/* hdl/weighted_path_selector_top.sv */
// Weighted path selector: path table, sequencer and shared shift-subtract divider.
`timescale 1ns / 1ps
// Update: written into the path table on acceptance, no result, busy stays low.
// Select (n = considered paths): min-RTT scan, then per eligible path a factor step, a
//   16-step penalty divide unless the penalty is off or floored, and a score multiply;
//   then a decision, and either two target-product steps, a (64 + log2 MAX)-step target
//   divide and a walk, or a 32-step modulo divide and a walk; the result is registered.
// Result strobe lasts one cycle and cannot be stalled; async active-low reset empties the table.
module weighted_path_selector_top
	import wps_pkg::*;
#(
	parameter int MAX_PATH_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [2:0]  path_slot,
	input  logic [31:0] bandwidth,
	input  logic [31:0] rtt_us,
	input  logic        link_up,
	input  logic        socket_open,
	input  logic [31:0] chunk_number,
	// result
	output logic        result_valid,
	output logic [2:0]  chosen_path,
	output logic        none_eligible,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int IW   = (MAX_PATH_COUNT > 1) ? $clog2(MAX_PATH_COUNT) : 1;
	localparam int CW   = $clog2(MAX_PATH_COUNT + 1);
	localparam int SW   = 32 + IW;          // score sum width
	localparam int PW   = 32 + SW;          // chunk * sum width
	localparam int CNTW = $clog2(PW + 1);

	// config registers
	logic [3:0]  paths_in_use_q;
	logic [15:0] thr_ms_q;
	logic [31:0] total_q;

	// path table
	logic [31:0] bw_q   [MAX_PATH_COUNT];
	logic [31:0] rtt_q  [MAX_PATH_COUNT];
	logic [MAX_PATH_COUNT-1:0] up_q;
	logic [MAX_PATH_COUNT-1:0] conn_q;
	logic [31:0] score_q [MAX_PATH_COUNT];

	// sequencer state
	state_t          state_q, state_d;
	logic [CW-1:0]   n_q;
	logic [CW-1:0]   i_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   ecnt_q;
	logic [31:0]     chunk_q;
	logic [31:0]     min_q;
	logic            have_min_q;
	logic [16:0]     f_q;
	logic [SW-1:0]   sum_q;
	logic [SW-1:0]   acc_q;
	logic [IW-1:0]   last_q;
	logic [63:0]     plo_q;

	// shared divider
	logic [31:0]     rem_q;
	logic [PW-1:0]   dvd_q;
	logic [31:0]     dsr_q;
	logic [CNTW-1:0] cnt_q;
	logic [32:0]     trial;
	logic            ge;
	logic [31:0]     rem_n;
	logic [PW-1:0]   dvd_n;

	// result
	logic            res_valid_q;
	logic [2:0]      chosen_q;
	logic            none_q;

	// combinational helpers
	logic            accept;
	logic [4:0]      piu_ext;
	logic [CW-1:0]   n_w;
	logic [IW-1:0]   ix;
	logic            i_end;
	logic            elig_i;
	logic [31:0]     rtt_i;
	logic [25:0]     thr_us;
	logic [28:0]     span;
	logic [31:0]     excess;
	logic [31:0]     diff;
	logic            pen_on;
	logic            pen_floor;
	logic [16:0]     f_div;
	logic [48:0]     sprod;
	logic [SW-1:0]   acc_n;
	logic            fin;
	logic            fin_none;
	logic [IW-1:0]   fin_pick;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	assign piu_ext = {1'b0, paths_in_use_q};
	assign n_w     = (int'(piu_ext) > MAX_PATH_COUNT) ? CW'(MAX_PATH_COUNT) : CW'(piu_ext);

	assign ix     = i_q[IW-1:0];
	assign i_end  = (i_q == n_q);
	assign elig_i = up_q[ix] && conn_q[ix];
	assign rtt_i  = rtt_q[ix];

	// penalty decision for the current entry
	assign thr_us    = {10'd0, thr_ms_q} * US_PER_MS;
	assign span      = {3'd0, thr_us} * PENALTY_SPAN;
	assign excess    = rtt_i - min_q;
	assign diff      = excess - {6'd0, thr_us};
	assign pen_on    = (rtt_i != 32'd0) && (rtt_i > min_q) && (excess > {6'd0, thr_us});
	assign pen_floor = (thr_us == 26'd0) || (diff >= {3'd0, span});

	// one restoring step: quotient bits shift into the dividend register
	assign trial = {rem_q, dvd_q[PW-1]};
	assign ge    = (trial >= {1'b0, dsr_q});
	assign rem_n = ge ? 32'(trial - {1'b0, dsr_q}) : trial[31:0];
	assign dvd_n = {dvd_q[PW-2:0], ge};
	assign f_div = (dvd_n[15:0] >= PEN_LIMIT) ? FACTOR_FLOOR : (FACTOR_ONE - {1'b0, dvd_n[15:0]});

	assign sprod = bw_q[ix] * f_q;
	assign acc_n = acc_q + SW'(score_q[ix]);

	// next state and finish decision
	always_comb begin
		state_d  = state_q;
		fin      = 1'b0;
		fin_none = 1'b0;
		fin_pick = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && kind) state_d = ST_MIN;
			end
			ST_MIN: begin
				if (i_end) state_d = ST_FAC;
			end
			ST_FAC: begin
				if (i_end) begin
					if (count_q == '0) begin
						fin      = 1'b1;
						fin_none = 1'b1;
						state_d  = ST_IDLE;
					end else if (sum_q == '0 || total_q == 32'd0) begin
						state_d = ST_MDIV;
					end else begin
						state_d = ST_TGT_LO;
					end
				end else if (elig_i) begin
					state_d = (pen_on && !pen_floor) ? ST_FDIV : ST_MUL;
				end
			end
			ST_FDIV: begin
				if (cnt_q == CNTW'(1)) state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_FAC;
			end
			ST_TGT_LO: begin
				state_d = ST_TGT_HI;
			end
			ST_TGT_HI: begin
				state_d = ST_TDIV;
			end
			ST_TDIV: begin
				if (cnt_q == CNTW'(1)) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (i_end) begin
					fin      = 1'b1;
					fin_pick = last_q;
					state_d  = ST_IDLE;
				end else if (elig_i && (dvd_q <= PW'(acc_n))) begin
					fin      = 1'b1;
					fin_pick = ix;
					state_d  = ST_IDLE;
				end
			end
			ST_MDIV: begin
				if (cnt_q == CNTW'(1)) state_d = ST_MWALK;
			end
			ST_MWALK: begin
				if (elig_i && (ecnt_q == rem_q[CW-1:0])) begin
					fin      = 1'b1;
					fin_pick = ix;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paths_in_use_q <= 4'd0;
			thr_ms_q       <= 16'd50;
			total_q        <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_PATHS_IN_USE:  paths_in_use_q <= cfg_data[3:0];
				CFG_LAT_THRESHOLD: thr_ms_q       <= cfg_data[15:0];
				CFG_TOTAL_CHUNKS:  total_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// path table, written by update items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PATH_COUNT; k++) begin
				bw_q[k]  <= 32'd0;
				rtt_q[k] <= 32'd0;
			end
			up_q   <= '0;
			conn_q <= '0;
		end else if (accept && !kind && (int'(path_slot) < MAX_PATH_COUNT)) begin
			bw_q[IW'(path_slot)]   <= bandwidth;
			rtt_q[IW'(path_slot)]  <= rtt_us;
			up_q[IW'(path_slot)]   <= link_up;
			conn_q[IW'(path_slot)] <= socket_open;
		end
	end

	// sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			i_q         <= '0;
			count_q     <= '0;
			ecnt_q      <= '0;
			have_min_q  <= 1'b0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= fin;
			case (state_q)
				ST_IDLE: begin
					n_q        <= n_w;
					i_q        <= '0;
					have_min_q <= 1'b0;
				end
				ST_MIN: begin
					if (i_end) begin
						i_q     <= '0;
						count_q <= '0;
					end else begin
						if (up_q[ix] && rtt_i != 32'd0 && (!have_min_q || rtt_i < min_q))
							have_min_q <= 1'b1;
						i_q <= i_q + CW'(1);
					end
				end
				ST_FAC: begin
					if (i_end) begin
						i_q    <= '0;
						ecnt_q <= '0;
						cnt_q  <= CNTW'(MOD_STEPS);
					end else if (!elig_i) begin
						i_q <= i_q + CW'(1);
					end else begin
						cnt_q <= CNTW'(FDIV_STEPS);
					end
				end
				ST_FDIV, ST_TDIV, ST_MDIV: begin
					cnt_q <= cnt_q - CNTW'(1);
				end
				ST_MUL: begin
					count_q <= count_q + CW'(1);
					i_q     <= i_q + CW'(1);
				end
				ST_TGT_HI: begin
					cnt_q <= CNTW'(PW);
				end
				ST_WALK, ST_MWALK: begin
					if (state_q == ST_MWALK && elig_i) ecnt_q <= ecnt_q + CW'(1);
					i_q <= i_q + CW'(1);
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				chunk_q <= chunk_number;
			end
			ST_MIN: begin
				if (i_end) begin
					if (!have_min_q) min_q <= NO_PATH_MIN_RTT;
					sum_q <= '0;
				end else if (up_q[ix] && rtt_i != 32'd0 && (!have_min_q || rtt_i < min_q)) begin
					min_q <= rtt_i;
				end
			end
			ST_FAC: begin
				if (i_end) begin
					rem_q <= 32'd0;
					dvd_q <= {chunk_q, {(PW-32){1'b0}}};
					dsr_q <= 32'(count_q);
				end else begin
					f_q   <= !pen_on ? FACTOR_ONE : FACTOR_FLOOR;
					rem_q <= diff;
					dvd_q <= '0;
					dsr_q <= {3'd0, span};
				end
			end
			ST_FDIV: begin
				rem_q <= rem_n;
				dvd_q <= dvd_n;
				if (cnt_q == CNTW'(1)) f_q <= f_div;
			end
			ST_MUL: begin
				score_q[ix] <= sprod[47:16];
				sum_q       <= sum_q + SW'(sprod[47:16]);
			end
			ST_TGT_LO: begin
				plo_q <= chunk_q * sum_q[31:0];
			end
			ST_TGT_HI: begin
				dvd_q <= PW'(plo_q) + (PW'(chunk_q * sum_q[SW-1:32]) << 32);
				rem_q <= 32'd0;
				dsr_q <= total_q;
				acc_q <= '0;
				last_q <= '0;
			end
			ST_TDIV, ST_MDIV: begin
				rem_q <= rem_n;
				dvd_q <= dvd_n;
			end
			ST_WALK: begin
				if (!i_end && elig_i) begin
					acc_q  <= acc_n;
					last_q <= ix;
				end
			end
			default: ;
		endcase
		// ST_TDIV last step leaves i at its walk start
		if (fin) begin
			chosen_q <= 3'(fin_pick);
			none_q   <= fin_none;
		end
	end

	// walk counter restart after the target divide
	// (i_q is zero from the FAC exit and untouched by TGT/TDIV)

	assign result_valid  = res_valid_q;
	assign chosen_path   = chosen_q;
	assign none_eligible = none_q;

`ifndef SYNTHESIS
	a_res_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without a select in progress");

	a_res_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one beat");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && none_eligible |-> chosen_path == 3'd0)
		else $error("none_eligible with nonzero path");

	a_select_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && kind |=> busy)
		else $error("select accepted but sequencer idle");

	a_update_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !kind |=> !busy)
		else $error("update started the sequencer");
`endif

endmodule
